// ----- rtl/core/qltu_pkg.sv -----
// ----------------------------------------------------------------------------
// qltu_pkg: shared types and constants of the Q-learning table update
// Holds the field widths, the register indexes and reset values, the
// sequencer state type and the command group passed from controller to
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qltu_pkg;

   // Field widths fixed by the interface.
   localparam int STATE_W  = 6;
   localparam int ACT_IN_W = 2;
   localparam int VALUE_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT   = 2'd1;

   // Register reset values, unsigned Q0.16.
   localparam logic [CSR_DATA_W-1:0] LEARN_RATE_RST = 16'd6554;
   localparam logic [CSR_DATA_W-1:0] DISCOUNT_RST   = 16'd62259;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_MAX      = 6'b000010,
      ST_MUL_DISC = 6'b000100,
      ST_DELTA    = 6'b001000,
      ST_MUL_RATE = 6'b010000,
      ST_COMMIT   = 6'b100000
   } qltu_state_type;

   // Step commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic find_max;
      logic mul_discount;
      logic form_delta;
      logic mul_rate;
      logic commit;
   } qltu_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/core/q_learning_table_update.sv -----
// ----------------------------------------------------------------------------
// q_learning_table_update: tabular Q-learning value update
// Top level joining the step sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Each request beat names a state, an action, a signed Q8.8 reward and the
// state that followed. The block reads the next state's row and the current
// entry, forms old + learn_rate * (reward + discount * best - old) with both
// products rounded to nearest (ties upward) and the sum saturated to Q8.8,
// writes it back and returns the new value with the best value of the next
// row as one response beat. Both rows are read before the write, so a
// transition into its own state sees the old row. All table entries read as
// zero after reset without any clearing pass: every row carries a valid bit
// that reset clears, and an unwritten row reads as zero. A next state beyond
// the board gives a best value of zero; a current state or action beyond the
// table takes the old value as zero and writes nothing. One request passes
// through six steps, one per cycle: row read at the accepting edge, row
// maximum, discount multiply, rounding and difference, rate multiply, then
// rounding, saturation and write-back. The write-back waits while an earlier
// response has not been taken and loads the response register. The next
// request is taken the cycle after write-back, so no request is taken before
// the last one is written back. The registers learn_rate (index 0) and
// discount (index 1) are written through the csr port; the user must write
// them only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module q_learning_table_update #(
   parameter int BOARD_SIDE   = 8,
   parameter int ACTION_COUNT = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Request channel.
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [qltu_pkg::STATE_W-1:0]           req_cur_state,
   input  wire logic [qltu_pkg::ACT_IN_W-1:0]          req_act_index,
   input  wire logic signed [qltu_pkg::VALUE_W-1:0]    req_reward_value,
   input  wire logic [qltu_pkg::STATE_W-1:0]           req_next_state,
   // Response channel.
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [qltu_pkg::VALUE_W-1:0]         rsp_updated_value,
   output logic signed [qltu_pkg::VALUE_W-1:0]         rsp_next_best,
   // Configuration write port.
   input  wire logic                                   csr_wr_en,
   input  wire logic [qltu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [qltu_pkg::CSR_DATA_W-1:0]        csr_wr_data
);
   import qltu_pkg::*;

   // The controller issues one step command per cycle but may hold the commit;
   // the datapath holds all operands between steps; the two share only cmd.
   qltu_cmd_type cmd;

   qltu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The table, configuration registers, arithmetic and the response
   // register live in the datapath.
   qltu_datapath #(
      .BOARD_SIDE   (BOARD_SIDE),
      .ACTION_COUNT (ACTION_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_cur_state     (req_cur_state),
      .req_act_index     (req_act_index),
      .req_reward_value  (req_reward_value),
      .req_next_state    (req_next_state),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_updated_value (rsp_updated_value),
      .rsp_next_best     (rsp_next_best)
   );

endmodule

`default_nettype wire

// ----- rtl/core/qltu_ctrl.sv -----
// ----------------------------------------------------------------------------
// qltu_ctrl: sequencer of the Q-learning table update
// Walks one accepted beat through the datapath steps and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module qltu_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output qltu_pkg::qltu_cmd_type     cmd
);
   import qltu_pkg::*;

   qltu_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           commit;

   assign accept = (state_ff == ST_IDLE) && req_valid;
   // The result can be written once the output register is free or being emptied.
   assign commit = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MAX;
         end
         ST_MAX:      state_in = ST_MUL_DISC;
         ST_MUL_DISC: state_in = ST_DELTA;
         ST_DELTA:    state_in = ST_MUL_RATE;
         ST_MUL_RATE: state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (commit) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load         = accept;
   assign cmd.find_max     = (state_ff == ST_MAX);
   assign cmd.mul_discount = (state_ff == ST_MUL_DISC);
   assign cmd.form_delta   = (state_ff == ST_DELTA);
   assign cmd.mul_rate     = (state_ff == ST_MUL_RATE);
   assign cmd.commit       = commit;

endmodule

`default_nettype wire

// ----- rtl/core/qltu_datapath.sv -----
// ----------------------------------------------------------------------------
// qltu_datapath: value table and update arithmetic
// Row-wide value memory with per-row valid bits, row maximum, the two
// rounded fixed-point multiplies, saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qltu_datapath #(
   parameter int BOARD_SIDE   = 8,
   parameter int ACTION_COUNT = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire qltu_pkg::qltu_cmd_type                 cmd,
   input  wire logic [qltu_pkg::STATE_W-1:0]           req_cur_state,
   input  wire logic [qltu_pkg::ACT_IN_W-1:0]          req_act_index,
   input  wire logic signed [qltu_pkg::VALUE_W-1:0]    req_reward_value,
   input  wire logic [qltu_pkg::STATE_W-1:0]           req_next_state,
   input  wire logic                                   csr_wr_en,
   input  wire logic [qltu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [qltu_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   output logic signed [qltu_pkg::VALUE_W-1:0]         rsp_updated_value,
   output logic signed [qltu_pkg::VALUE_W-1:0]         rsp_next_best
);
   import qltu_pkg::*;

   localparam int STATE_COUNT = BOARD_SIDE * BOARD_SIDE;
   localparam int ADDR_STATES = 1 << STATE_W;
   // Only states reachable through the state field need storage.
   localparam int ROWS     = (STATE_COUNT < ADDR_STATES) ? STATE_COUNT : ADDR_STATES;
   localparam int ROW_W    = $clog2(ROWS);
   localparam int ACT_W    = $clog2(ACTION_COUNT);
   localparam int ROW_BITS = ACTION_COUNT * VALUE_W;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] learn_rate_ff;
   logic [CSR_DATA_W-1:0] discount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= LEARN_RATE_RST;
         discount_ff   <= DISCOUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LEARN_RATE: learn_rate_ff <= csr_wr_data;
            CSR_DISCOUNT:   discount_ff   <= csr_wr_data;
            default:        ;
         endcase
      end
   end

   // Row memory and row valid bits. A row that was never written reads as zero.
   logic [ROW_BITS-1:0] table_mem [ROWS];
   logic [ROWS-1:0]     row_vld_ff;

   logic [ROW_W-1:0]    req_cur_row;
   logic [ROW_W-1:0]    req_next_row;
   logic [ACT_W+1:0]    req_act_ext;
   logic                req_cur_ok;
   logic                req_next_ok;

   assign req_cur_row  = req_cur_state[ROW_W-1:0];
   assign req_next_row = req_next_state[ROW_W-1:0];
   assign req_act_ext  = (ACT_W+2)'(req_act_index);
   assign req_cur_ok   = (int'(req_cur_state) < STATE_COUNT) &&
                         (int'(req_act_index) < ACTION_COUNT);
   assign req_next_ok  = (int'(req_next_state) < STATE_COUNT);

   logic [ROW_BITS-1:0]       cur_rd_ff;
   logic [ROW_BITS-1:0]       next_rd_ff;
   logic [ROW_BITS-1:0]       new_row;
   logic                      cur_ok_ff;
   logic                      cur_vld_ff;
   logic                      next_vld_ff;
   logic [ROW_W-1:0]          cur_row_ff;
   logic [ACT_W-1:0]          act_sel_ff;
   logic signed [VALUE_W-1:0] reward_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_rd_ff   <= table_mem[req_cur_row];
         next_rd_ff  <= table_mem[req_next_row];
      end
      if (cmd.commit && cur_ok_ff) begin
         table_mem[cur_row_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (cmd.commit && cur_ok_ff) begin
         row_vld_ff[cur_row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ok_ff   <= req_cur_ok;
         cur_vld_ff  <= req_cur_ok && row_vld_ff[req_cur_row];
         next_vld_ff <= req_next_ok && row_vld_ff[req_next_row];
         cur_row_ff  <= req_cur_row;
         act_sel_ff  <= req_act_ext[ACT_W-1:0];
         reward_ff   <= req_reward_value;
      end
   end

   // Row maximum of the next state and the old entry of the current state.
   logic signed [VALUE_W-1:0] best_in, best_ff;
   logic signed [VALUE_W-1:0] old_in, old_ff;
   logic signed [VALUE_W-1:0] next_entry [ACTION_COUNT];
   logic signed [VALUE_W-1:0] cur_entry [ACTION_COUNT];

   always_comb begin
      for (int a = 0; a < ACTION_COUNT; a++) begin
         next_entry[a] = next_rd_ff[a*VALUE_W +: VALUE_W];
         cur_entry[a]  = cur_rd_ff[a*VALUE_W +: VALUE_W];
      end
      best_in = next_entry[0];
      for (int a = 1; a < ACTION_COUNT; a++) begin
         if (next_entry[a] > best_in) best_in = next_entry[a];
      end
      if (!next_vld_ff) best_in = '0;
      old_in = cur_vld_ff ? cur_entry[act_sel_ff] : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.find_max) begin
         best_ff <= best_in;
         old_ff  <= old_in;
      end
   end

   // discount * best, Q8.24.
   logic signed [32:0] disc_prod_in, disc_prod_ff;
   assign disc_prod_in = 33'($signed({1'b0, discount_ff})) * 33'(best_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_discount) disc_prod_ff <= disc_prod_in;
   end

   // Round to nearest with ties upward, then form reward + term - old exactly.
   logic signed [32:0] disc_shift;
   logic signed [16:0] disc_round;
   logic signed [17:0] delta_in, delta_ff;

   assign disc_shift = (disc_prod_ff + 33'sd32768) >>> 16;
   assign disc_round = disc_shift[16:0];
   assign delta_in   = 18'(reward_ff) + 18'(disc_round) - 18'(old_ff);

   always_ff @(posedge clock) begin
      if (cmd.form_delta) delta_ff <= delta_in;
   end

   // learn_rate * delta.
   logic signed [34:0] rate_prod_in, rate_prod_ff;
   assign rate_prod_in = 35'($signed({1'b0, learn_rate_ff})) * 35'(delta_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_rate) rate_prod_ff <= rate_prod_in;
   end

   // Round, add to the old value and saturate to Q8.8.
   logic signed [34:0]        rate_shift;
   logic signed [18:0]        rate_round;
   logic signed [19:0]        sum;
   logic signed [VALUE_W-1:0] result;

   assign rate_shift = (rate_prod_ff + 35'sd32768) >>> 16;
   assign rate_round = rate_shift[18:0];
   assign sum        = 20'(old_ff) + 20'(rate_round);

   always_comb begin
      if (sum > 20'sd32767) begin
         result = 16'sh7fff;
      end else if (sum < -20'sd32768) begin
         result = 16'sh8000;
      end else begin
         result = sum[VALUE_W-1:0];
      end
   end

   // Write-back row: the chosen entry gets the result, the rest keep their value.
   always_comb begin
      for (int a = 0; a < ACTION_COUNT; a++) begin
         if (ACT_W'(a) == act_sel_ff) begin
            new_row[a*VALUE_W +: VALUE_W] = result;
         end else begin
            new_row[a*VALUE_W +: VALUE_W] = cur_vld_ff ? cur_entry[a] : '0;
         end
      end
   end

   logic signed [VALUE_W-1:0] rsp_updated_ff;
   logic signed [VALUE_W-1:0] rsp_best_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_updated_ff <= result;
         rsp_best_ff    <= best_ff;
      end
   end

   assign rsp_updated_value = rsp_updated_ff;
   assign rsp_next_best     = rsp_best_ff;

endmodule

`default_nettype wire
